// ----- hdl/mbfr_pkg.sv -----
// Shared types and constants for the MSB-first bit field reader.
// Used by the controller, the datapath and the top level; no dependencies.

package mbfr_pkg;

    localparam int unsigned FIELD_WIDTH_W = 7;
    localparam int unsigned VALUE_W       = 64;
    localparam logic [3:0]  BYTE_BITS     = 4'd8;

    typedef enum logic [1:0] {
        OP_START  = 2'd0,
        OP_APPEND = 2'd1,
        OP_READ   = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_AT_END  = 2'd1,
        ST_RAN_OUT = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CUR,
        S_STEP,
        S_DONE
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic start;
        logic append;
        logic begin_read;
        logic capture;
        logic step;
        logic emit;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic step_finish;
        logic out_free;
    } dp_stat_t;

endpackage

// ----- hdl/mbfr_ctrl.sv -----
// Controller state machine of the MSB-first bit field reader.
// Depends on mbfr_pkg; drives the datapath through dp_cmd_t.

module mbfr_ctrl
    import mbfr_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    input  logic     [1:0] in_op,
    output logic     in_ready,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    state_t state_reg;
    state_t state_next;
    logic   accept;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign accept = in_valid && in_ready;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (accept)
                begin
                    case (op_t'(in_op))
                        OP_START:  cmd.start = 1'b1;
                        OP_APPEND: cmd.append = 1'b1;
                        OP_READ:
                        begin
                            cmd.begin_read = 1'b1;
                            state_next     = S_CUR;
                        end
                        default: ;
                    endcase
                end
            end
            S_CUR:
            begin
                cmd.capture = 1'b1;
                state_next  = S_STEP;
            end
            S_STEP:
            begin
                cmd.step = 1'b1;
                if (stat.step_finish)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (stat.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

endmodule

// ----- hdl/mbfr_datapath.sv -----
// Datapath of the MSB-first bit field reader: byte memory, position registers,
// the one-byte-per-cycle extraction step and the output register. Uses mbfr_pkg.

module mbfr_datapath
    import mbfr_pkg::*;
#(
    parameter int unsigned BUFFER_BYTES = 1024
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  dp_cmd_t                  cmd,
    output dp_stat_t                 stat,
    input  logic [7:0]               in_data_byte,
    input  logic [FIELD_WIDTH_W-1:0] in_field_width,
    output logic [VALUE_W-1:0]       out_value,
    output logic [1:0]               out_status,
    output logic                     out_valid,
    input  logic                     out_ready
);

    localparam int unsigned AW = (BUFFER_BYTES > 1) ? $clog2(BUFFER_BYTES) : 1;
    localparam int unsigned LW = $clog2(BUFFER_BYTES + 1);
    localparam logic [LW-1:0] DEPTH = LW'(BUFFER_BYTES);

    logic [7:0] mem [BUFFER_BYTES];
    logic [7:0] rdata_reg;
    logic [AW-1:0] raddr;

    logic [LW-1:0] len_reg;
    logic [LW-1:0] off_reg;
    logic [3:0]    bl_reg;
    logic [7:0]    cur_reg;
    logic [FIELD_WIDTH_W-1:0] n_reg;
    logic [VALUE_W-1:0] acc_reg;
    logic [VALUE_W-1:0] res_value_reg;
    status_t            res_status_reg;
    logic [VALUE_W-1:0] out_value_reg;
    status_t            out_status_reg;
    logic               out_valid_reg;

    logic          at_end;
    logic          byte_mode;
    logic [3:0]    take;
    logic          adv;
    logic [LW-1:0] off_inc;
    logic          ran_out;
    logic [15:0]   window;
    logic [7:0]    bits;
    logic [VALUE_W-1:0] acc_new;
    logic [3:0]    bl_new;
    logic          write_en;

    assign at_end    = off_reg >= len_reg;
    assign byte_mode = n_reg >= FIELD_WIDTH_W'(8);
    assign take      = byte_mode ? BYTE_BITS : {1'b0, n_reg[2:0]};
    assign off_inc   = off_reg + LW'(1);

    // A byte step moves on unless the current byte is still whole; a short
    // step moves on when it wants more bits than the current byte has left.
    assign adv = byte_mode ? (bl_reg != BYTE_BITS)
                           : (n_reg > {{(FIELD_WIDTH_W-4){1'b0}}, bl_reg});
    assign ran_out = adv && (off_inc >= len_reg);

    // Current and next byte side by side, consumed bits shifted out at the top.
    assign window  = {cur_reg, rdata_reg} << (BYTE_BITS - bl_reg);
    assign bits    = window[15:8] >> (BYTE_BITS - take);
    assign acc_new = (acc_reg << take) | {{(VALUE_W-8){1'b0}}, bits};

    always_comb
    begin
        if (byte_mode)
        begin
            bl_new = (bl_reg == BYTE_BITS) ? 4'd0 : bl_reg;
        end
        else if (adv)
        begin
            bl_new = bl_reg + BYTE_BITS - {1'b0, n_reg[2:0]};
        end
        else
        begin
            bl_new = bl_reg - {1'b0, n_reg[2:0]};
        end
    end

    // Reads off_reg on begin_read, else the byte after the next step's byte.
    always_comb
    begin
        if (cmd.begin_read)
        begin
            raddr = off_reg[AW-1:0];
        end
        else if (cmd.step && (n_reg != '0) && !at_end && adv)
        begin
            raddr = AW'(off_inc + LW'(1));
        end
        else
        begin
            raddr = off_inc[AW-1:0];
        end
    end

    assign write_en = cmd.append && (len_reg < DEPTH);

    always_ff @(posedge clk)
    begin
        if (write_en)
        begin
            mem[len_reg[AW-1:0]] <= in_data_byte;
        end
        rdata_reg <= mem[raddr];
    end

    assign stat.step_finish = (n_reg == '0) || at_end || ran_out;
    assign stat.out_free    = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg <= '0;
            off_reg <= '0;
            bl_reg  <= BYTE_BITS;
        end
        else if (cmd.start)
        begin
            len_reg <= '0;
            off_reg <= '0;
            bl_reg  <= BYTE_BITS;
        end
        else if (write_en)
        begin
            len_reg <= len_reg + LW'(1);
        end
        else if (cmd.step && (n_reg != '0) && !at_end)
        begin
            if (adv)
            begin
                off_reg <= off_inc;
            end
            if (!ran_out)
            begin
                bl_reg <= bl_new;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.begin_read)
        begin
            n_reg   <= in_field_width;
            acc_reg <= '0;
        end
        else if (cmd.capture)
        begin
            cur_reg <= rdata_reg;
        end
        else if (cmd.step)
        begin
            if (n_reg == '0)
            begin
                res_value_reg  <= acc_reg;
                res_status_reg <= ST_OK;
            end
            else if (at_end)
            begin
                res_value_reg  <= '0;
                res_status_reg <= ST_AT_END;
            end
            else if (ran_out)
            begin
                res_value_reg  <= '0;
                res_status_reg <= ST_RAN_OUT;
            end
            else
            begin
                acc_reg <= acc_new;
                n_reg   <= n_reg - FIELD_WIDTH_W'(take);
                if (adv)
                begin
                    cur_reg <= rdata_reg;
                end
            end
        end
        if (cmd.emit)
        begin
            out_value_reg  <= res_value_reg;
            out_status_reg <= res_status_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_value  = out_value_reg;
    assign out_status = out_status_reg;
    assign out_valid  = out_valid_reg;

endmodule

// ----- hdl/msb_first_bit_field_reader.sv -----
// MSB-first bit field reader, top level.
// Instantiates mbfr_ctrl and mbfr_datapath; uses mbfr_pkg.
//
// Usage:
// The slave channel takes one command item at a time; tuser carries the
// operation (start, append, read) and tdata the byte to append and the field
// width. Start and append give no result. A read of W bits (0 to 127) gives
// one result item on the master channel: tdata holds the value right aligned,
// tuser the status (ok, at end, ran out). A read captures the current byte,
// then steps through the stored bytes, one per cycle from the single read
// port of the buffer memory, until the result register is loaded.
// The block takes a new item only when the previous read has finished; it
// may accept further items while a result waits on the master side, and a
// read that finishes while the master stalls waits until the result
// register is free. Reset empties the buffer (length zero, byte 0, eight
// bits left) and drops any pending result; there is no clearing pass.

module msb_first_bit_field_reader
    import mbfr_pkg::*;
#(
    parameter int unsigned BUFFER_BYTES = 1024
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,  // [7:0] data_byte, [14:8] field_width, [15] zero
    input  logic [1:0]  s_axis_tuser,  // [1:0] operation
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,  // [63:0] field_value
    output logic [1:0]  m_axis_tuser   // [1:0] status
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    mbfr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_op    (s_axis_tuser),
        .in_ready (s_axis_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    mbfr_datapath #(
        .BUFFER_BYTES (BUFFER_BYTES)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .in_data_byte   (s_axis_tdata[7:0]),
        .in_field_width (s_axis_tdata[14:8]),
        .out_value      (m_axis_tdata),
        .out_status     (m_axis_tuser),
        .out_valid      (m_axis_tvalid),
        .out_ready      (m_axis_tready)
    );

endmodule
